// ----- hdl/fdbb_pkg.sv -----
// Package for the frame difference bounding box block.
// Holds the payload and summary structs, the back-end state type and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fdbb_pkg;

  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int PIXEL_W       = 32;
  localparam int OUT_POS_W     = 12;
  localparam int POS_MAX_W     = 13;
  localparam int FRAC_W        = 16;
  localparam int RATIO_W       = 17;
  localparam int DIV_W         = POS_MAX_W + FRAC_W;
  localparam int DIV_CNT_W     = $clog2(DIV_W);
  localparam int NUM_LANES     = 4;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] base_pixel;
    logic [PIXEL_W-1:0] other_pixel;
  } pixel_pair_t;

  typedef struct packed {
    logic               found;
    logic [OUT_POS_W-1:0] box_x;
    logic [OUT_POS_W-1:0] box_y;
    logic [CFG_W-1:0]   box_width;
    logic [CFG_W-1:0]   box_height;
    logic [RATIO_W-1:0] x_ratio;
    logic [RATIO_W-1:0] y_ratio;
    logic [RATIO_W-1:0] box_w_ratio;
    logic [RATIO_W-1:0] box_h_ratio;
  } result_t;

  // One finished frame as handed from the front end to the divider.
  typedef struct packed {
    logic                 found;
    logic [POS_MAX_W-1:0] least_x;
    logic [POS_MAX_W-1:0] least_y;
    logic [POS_MAX_W-1:0] span_x;
    logic [POS_MAX_W-1:0] span_y;
    logic [CFG_W-1:0]     dim_x;
    logic [CFG_W-1:0]     dim_y;
  } summary_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// ----- hdl/fdbb_front.sv -----
// Front end: configuration registers, raster position counter and box tracking.
// Pushes one frame summary into the queue at the last pixel. Uses fdbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdbb_front #(
  parameter int POS_W   = 12,
  parameter int DIM_CAP = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [fdbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fdbb_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           pixel_valid,
  input  wire fdbb_pkg::pixel_pair_t          pixel,
  input  wire fdbb_pkg::queue_status_t        q_status,
  output logic                                push,
  output fdbb_pkg::summary_t                  summary
);
  import fdbb_pkg::*;

  localparam logic [CFG_W-1:0] CAP = CFG_W'(DIM_CAP);

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [POS_W-1:0] column;
  logic [POS_W-1:0] row;
  logic             any_diff;
  logic [POS_W-1:0] least_x;
  logic [POS_W-1:0] greatest_x;
  logic [POS_W-1:0] least_y;
  logic [POS_W-1:0] greatest_y;

  logic [CFG_W-1:0] dim_x;
  logic [CFG_W-1:0] dim_y;
  logic [POS_W:0]   column_inc;
  logic [POS_W:0]   row_inc;
  logic             row_end;
  logic             frame_end;
  logic             accept;
  logic             differ;
  logic             any_diff_next;
  logic [POS_W-1:0] least_x_next;
  logic [POS_W-1:0] greatest_x_next;
  logic [POS_W-1:0] least_y_next;
  logic [POS_W-1:0] greatest_y_next;
  logic [POS_W:0]   span_x;
  logic [POS_W:0]   span_y;

  always_comb begin
    dim_x = (frame_width == '0) ? CFG_W'(1) : ((frame_width > CAP) ? CAP : frame_width);
    dim_y = (frame_height == '0) ? CFG_W'(1) : ((frame_height > CAP) ? CAP : frame_height);
  end

  assign column_inc = {1'b0, column} + (POS_W+1)'(1);
  assign row_inc    = {1'b0, row} + (POS_W+1)'(1);
  assign row_end    = (CFG_W+1)'(column_inc) >= {1'b0, dim_x};
  assign frame_end  = row_end && ((CFG_W+1)'(row_inc) >= {1'b0, dim_y});
  assign accept     = pixel_valid && !q_status.full;
  assign differ     = pixel.base_pixel != pixel.other_pixel;

  always_comb begin
    any_diff_next   = any_diff || differ;
    least_x_next    = least_x;
    greatest_x_next = greatest_x;
    least_y_next    = least_y;
    greatest_y_next = greatest_y;
    if (differ) begin
      if (!any_diff) begin
        least_x_next    = column;
        greatest_x_next = column;
        least_y_next    = row;
        greatest_y_next = row;
      end else begin
        if (column < least_x)    least_x_next    = column;
        if (column > greatest_x) greatest_x_next = column;
        if (row < least_y)       least_y_next    = row;
        if (row > greatest_y)    greatest_y_next = row;
      end
    end
    span_x = {1'b0, greatest_x_next} - {1'b0, least_x_next} + (POS_W+1)'(1);
    span_y = {1'b0, greatest_y_next} - {1'b0, least_y_next} + (POS_W+1)'(1);
  end

  assign push = accept && frame_end;

  always_comb begin
    summary.found   = any_diff_next;
    summary.least_x = POS_MAX_W'(least_x_next);
    summary.least_y = POS_MAX_W'(least_y_next);
    summary.span_x  = POS_MAX_W'(span_x);
    summary.span_y  = POS_MAX_W'(span_y);
    summary.dim_x   = dim_x;
    summary.dim_y   = dim_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      column       <= '0;
      row          <= '0;
      any_diff     <= 1'b0;
      least_x      <= '0;
      greatest_x   <= '0;
      least_y      <= '0;
      greatest_y   <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (frame_end) begin
          column     <= '0;
          row        <= '0;
          any_diff   <= 1'b0;
          least_x    <= '0;
          greatest_x <= '0;
          least_y    <= '0;
          greatest_y <= '0;
        end else begin
          any_diff   <= any_diff_next;
          least_x    <= least_x_next;
          greatest_x <= greatest_x_next;
          least_y    <= least_y_next;
          greatest_y <= greatest_y_next;
          if (row_end) begin
            column <= '0;
            row    <= POS_W'(row_inc);
          end else begin
            column <= POS_W'(column_inc);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fdbb_queue.sv -----
// Short queue of frame summaries between the front end and the divider.
// Uses fdbb_pkg for the summary struct and its depth.
`timescale 1ns / 1ps
`default_nettype none

module fdbb_queue (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire fdbb_pkg::summary_t      push_data,
  input  wire logic                    pop,
  output fdbb_pkg::summary_t           pop_data,
  output fdbb_pkg::queue_status_t      status
);
  import fdbb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  summary_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = count == CNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fdbb_back.sv -----
// Back end: four restoring dividers, one quotient bit per cycle each, and the result register.
// Takes frame summaries from the queue. Uses fdbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdbb_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire fdbb_pkg::queue_status_t q_status,
  input  wire fdbb_pkg::summary_t      summary,
  output logic                         pop,
  output logic                         result_valid,
  input  wire logic                    result_stall,
  output fdbb_pkg::result_t            result
);
  import fdbb_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  logic [DIV_CNT_W-1:0] step;
  logic                 load_out;
  summary_t             held;

  logic [DIV_W-1:0]     quot      [NUM_LANES];
  logic [POS_MAX_W-1:0] rem       [NUM_LANES];
  logic [CFG_W-1:0]     den       [NUM_LANES];
  logic [POS_MAX_W-1:0] load_num  [NUM_LANES];
  logic [CFG_W-1:0]     load_den  [NUM_LANES];
  logic [POS_MAX_W:0]   trial     [NUM_LANES];
  logic                 fits      [NUM_LANES];
  logic [POS_MAX_W:0]   trial_sub [NUM_LANES];

  always_comb begin
    load_num[0] = summary.least_x;  load_den[0] = summary.dim_x;
    load_num[1] = summary.least_y;  load_den[1] = summary.dim_y;
    load_num[2] = summary.span_x;   load_den[2] = summary.dim_x;
    load_num[3] = summary.span_y;   load_den[3] = summary.dim_y;
  end

  // The partial remainder stays below the divisor, so one extra bit holds the trial value.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      trial[i]     = {rem[i], quot[i][DIV_W-1]};
      fits[i]      = trial[i] >= {1'b0, den[i]};
      trial_sub[i] = trial[i] - {1'b0, den[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          state_next = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (step == DIV_CNT_W'(DIV_W - 1)) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!result_valid || !result_stall) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held <= summary;
      step <= '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        quot[i] <= {load_num[i], FRAC_W'(0)};
        rem[i]  <= '0;
        den[i]  <= load_den[i];
      end
    end else if (state == BK_DIVIDE) begin
      step <= step + DIV_CNT_W'(1);
      for (int i = 0; i < NUM_LANES; i++) begin
        quot[i] <= {quot[i][DIV_W-2:0], fits[i]};
        rem[i]  <= fits[i] ? POS_MAX_W'(trial_sub[i]) : POS_MAX_W'(trial[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (held.found) begin
        result.found       <= 1'b1;
        result.box_x       <= held.least_x[OUT_POS_W-1:0];
        result.box_y       <= held.least_y[OUT_POS_W-1:0];
        result.box_width   <= CFG_W'(held.span_x);
        result.box_height  <= CFG_W'(held.span_y);
        result.x_ratio     <= quot[0][RATIO_W-1:0];
        result.y_ratio     <= quot[1][RATIO_W-1:0];
        result.box_w_ratio <= quot[2][RATIO_W-1:0];
        result.box_h_ratio <= quot[3][RATIO_W-1:0];
      end else begin
        result <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/frame_diff_bounding_box.sv -----
// Frame difference bounding box. Throughput: one pixel pair per cycle while the summary
// queue has room. Each frame result passes through a load step, the division steps of the
// four shared-clock restoring dividers and an output step, which waits while the result is
// stalled. Frames that arrive faster than the divider finishes them stall the input when the
// two-entry queue fills. Synchronous active-high reset restores 640 x 480 and clears tracking.
`timescale 1ns / 1ps
`default_nettype none

module frame_diff_bounding_box #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [fdbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fdbb_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           pixel_valid,
  output logic                                pixel_stall,
  input  wire fdbb_pkg::pixel_pair_t          pixel,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output fdbb_pkg::result_t                   result
);
  import fdbb_pkg::*;

  // Configured dimensions are 13 bits wide, so positions never need more than 13 bits.
  localparam int DIM_LIMIT = (1 << CFG_W) - 1;
  localparam int DIM_CAP   = (MAX_DIM > DIM_LIMIT) ? DIM_LIMIT : MAX_DIM;
  localparam int POS_W     = ($clog2(MAX_DIM) > POS_MAX_W) ? POS_MAX_W : $clog2(MAX_DIM);

  logic          push;
  logic          pop;
  summary_t      push_data;
  summary_t      pop_data;
  queue_status_t q_status;

  assign pixel_stall = q_status.full;

  fdbb_front #(
    .POS_W   (POS_W),
    .DIM_CAP (DIM_CAP)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel       (pixel),
    .q_status    (q_status),
    .push        (push),
    .summary     (push_data)
  );

  fdbb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  fdbb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .summary      (pop_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef NO_ASSERTIONS
  a_reset_clears : assert property (@(posedge clk)
    rst |=> !result_valid && q_status.empty)
    else $error("result or queue not cleared by reset");

  a_pop_not_empty : assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("divider took a summary from an empty queue");

  a_found_box : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.found |-> result.box_width != '0 && result.box_height != '0)
    else $error("found result with an empty box");

  a_none_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.box_x == '0 && result.box_y == '0 &&
      result.box_width == '0 && result.box_height == '0 && result.x_ratio == '0 &&
      result.y_ratio == '0 && result.box_w_ratio == '0 && result.box_h_ratio == '0)
    else $error("empty result carries non-zero fields");
`endif

endmodule

`default_nettype wire

// ----- dv/frame_diff_bounding_box_test.sv -----
// Testbench for frame_diff_bounding_box: streams pixel pairs, predicts each frame's box
// and ratios, and checks every result transaction against the prediction.
// Depends on fdbb_pkg and the frame_diff_bounding_box RTL only.
`timescale 1ns / 1ps

module frame_diff_bounding_box_test;
  import fdbb_pkg::*;

  localparam int MAX_DIM = 4096;
  localparam longint RATIO_ONE = 65536;
  localparam int RANDOM_PIXELS = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    bit          wr_w;
    logic [12:0] w;
    bit          wr_h;
    logic [12:0] h;
    int          ax, ay, bx, by;
    logic [31:0] base_word;
    logic [31:0] flip;
    bit          typed;
    result_t     want;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  cfg_reg_t    cfg_index = REG_FRAME_WIDTH;
  logic [12:0] cfg_data = '0;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  pixel_pair_t pixel = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;

  // Predictor state: programmed registers and the tracking of the frame in flight.
  logic [12:0] cur_w = 13'd640;
  logic [12:0] cur_h = 13'd480;
  int col = 0, row = 0;
  bit seen = 1'b0;
  int lo_x = 0, hi_x = 0, lo_y = 0, hi_y = 0;

  result_t pending_boxes[$];
  bit failed = 1'b0;
  bit no_idle = 1'b0;
  bit squeeze_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int random_sent = 0;
  frame_row_t plan [12];

  frame_diff_bounding_box uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  function automatic int used_dim(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [16:0] q16_ratio(input int num, input int den);
    return 17'((longint'(num) * RATIO_ONE) / longint'(den));
  endfunction

  // Advances the raster position by one pixel pair; returns 1 with the box at frame end.
  function automatic bit track_pixel(input pixel_pair_t p, output result_t r);
    int w, h, bw, bh;
    bit row_end, frame_end;
    w = used_dim(cur_w);
    h = used_dim(cur_h);
    row_end = (col + 1 >= w);
    frame_end = row_end && (row + 1 >= h);
    r = '0;
    if (p.base_pixel != p.other_pixel) begin
      if (!seen) begin
        lo_x = col; hi_x = col; lo_y = row; hi_y = row;
        seen = 1'b1;
      end else begin
        if (col < lo_x) lo_x = col;
        if (col > hi_x) hi_x = col;
        if (row < lo_y) lo_y = row;
        if (row > hi_y) hi_y = row;
      end
    end
    if (!frame_end) begin
      if (row_end) begin
        col = 0;
        row = row + 1;
      end else begin
        col = col + 1;
      end
      return 1'b0;
    end
    if (seen) begin
      bw = hi_x - lo_x + 1;
      bh = hi_y - lo_y + 1;
      r.found = 1'b1;
      r.box_x = 12'(lo_x);
      r.box_y = 12'(lo_y);
      r.box_width = 13'(bw);
      r.box_height = 13'(bh);
      r.x_ratio = q16_ratio(lo_x, w);
      r.y_ratio = q16_ratio(lo_y, h);
      r.box_w_ratio = q16_ratio(bw, w);
      r.box_h_ratio = q16_ratio(bh, h);
    end
    col = 0; row = 0; seen = 1'b0;
    lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
    return 1'b1;
  endfunction

  // Offers one pixel pair; called at a falling edge and returns at a falling edge.
  task automatic push_pair(input pixel_pair_t p, input bit typed, input result_t want);
    result_t box;
    while (!no_idle && $urandom_range(99) < 22) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    if (track_pixel(p, box)) pending_boxes.push_back(typed ? want : box);
    @(negedge clk);
  endtask

  // Waits until every expected result has arrived and the divider has had time to drain.
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    @(negedge clk);
    while (pending_boxes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_frame_size(input bit wr_w, input logic [12:0] w,
                                input bit wr_h, input logic [12:0] h);
    wait_idle();
    if (wr_w) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_FRAME_WIDTH;
      cfg_data <= w;
      @(negedge clk);
      cur_w = w;
    end
    if (wr_h) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_FRAME_HEIGHT;
      cfg_data <= h;
      @(negedge clk);
      cur_h = h;
    end
    cfg_write <= 1'b0;
  endtask

  task automatic send_planned_frame(input frame_row_t fr);
    pixel_pair_t p;
    logic [31:0] b;
    for (int y = 0; y < used_dim(cur_h); y++) begin
      for (int x = 0; x < used_dim(cur_w); x++) begin
        if ((x == fr.ax && y == fr.ay) || (x == fr.bx && y == fr.by)) begin
          p.base_pixel = fr.base_word;
          p.other_pixel = fr.base_word ^ fr.flip;
        end else begin
          b = $urandom;
          p.base_pixel = b;
          p.other_pixel = b;
        end
        push_pair(p, fr.typed, fr.want);
      end
    end
  endtask

  // Styles: no difference, sparse differences, dense differences, one differing pixel.
  task automatic send_random_frame(input int style);
    int w, h, spot_x, spot_y;
    bit differ;
    logic [31:0] b, m;
    pixel_pair_t p;
    w = used_dim(cur_w);
    h = used_dim(cur_h);
    spot_x = $urandom_range(w - 1);
    spot_y = $urandom_range(h - 1);
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        case (style)
          0: differ = 1'b0;
          1: differ = ($urandom_range(7) == 0);
          2: differ = $urandom_range(1);
          default: differ = (x == spot_x && y == spot_y);
        endcase
        b = $urandom;
        if ($urandom_range(1)) m = 32'($urandom_range(255, 1)) << (8 * $urandom_range(3));
        else m = $urandom | 32'h1;
        p.base_pixel = b;
        p.other_pixel = differ ? (b ^ m) : b;
        push_pair(p, 1'b0, '0);
        random_sent++;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_boxes.size() == 0) begin
        $error("result transaction with no frame outstanding");
        failed = 1'b1;
      end else begin
        want = pending_boxes.pop_front();
        check_field("found", 32'(want.found), 32'(result.found));
        check_field("box_x", 32'(want.box_x), 32'(result.box_x));
        check_field("box_y", 32'(want.box_y), 32'(result.box_y));
        check_field("box_width", 32'(want.box_width), 32'(result.box_width));
        check_field("box_height", 32'(want.box_height), 32'(result.box_height));
        check_field("x_ratio", 32'(want.x_ratio), 32'(result.x_ratio));
        check_field("y_ratio", 32'(want.y_ratio), 32'(result.y_ratio));
        check_field("box_w_ratio", 32'(want.box_w_ratio), 32'(result.box_w_ratio));
        check_field("box_h_ratio", 32'(want.box_h_ratio), 32'(result.box_h_ratio));
      end
    end
  end

  // Result side: random stalls, plus one long hold-off so that the summary queue fills.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (squeeze_go && !hold_done) begin
      result_stall <= 1'b1;
      hold_left <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
    end else begin
      result_stall <= !no_idle && ($urandom_range(99) < 22);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int phase;
    int pick;
    logic [12:0] w, h;
    // The first row runs on the reset height of 480 rows.
    plan = '{
      '{1, 1, 0, 0, 0, 479, -1, -1, 32'h12345678, 32'h00000001, 1,
        result_t'{1, 0, 479, 1, 1, 0, 65399, 65536, 136}},
      '{1, 4, 1, 3, -1, -1, -1, -1, 32'h0, 32'h0, 1, result_t'(0)},
      '{0, 0, 0, 0, 1, 1, 2, 2, 32'h00000000, 32'h000000FF, 0, result_t'(0)},
      '{0, 0, 0, 0, 3, 0, -1, -1, 32'hFFFFFFFF, 32'h0000FF00, 0, result_t'(0)},
      '{0, 0, 0, 0, 0, 2, 3, 2, 32'hA5A5A5A5, 32'h00FF0000, 0, result_t'(0)},
      '{0, 0, 0, 0, 0, 0, 3, 2, 32'hFFFFFFFF, 32'hFF000000, 1,
        result_t'{1, 0, 0, 4, 3, 0, 0, 65536, 65536}},
      '{1, 0, 1, 0, 0, 0, -1, -1, 32'h00000000, 32'hFFFFFFFF, 1,
        result_t'{1, 0, 0, 1, 1, 0, 0, 65536, 65536}},
      '{0, 0, 0, 0, -1, -1, -1, -1, 32'h0, 32'h0, 1, result_t'(0)},
      '{1, 3, 1, 5, 2, 0, 0, 4, 32'h00000000, 32'h01010101, 0, result_t'(0)},
      '{1, 7, 0, 0, 3, 2, 5, 1, 32'hDEADBEEF, 32'h00000100, 0, result_t'(0)},
      '{0, 0, 0, 0, 6, 4, 0, 0, 32'h00000000, 32'h01000000, 1,
        result_t'{1, 0, 0, 7, 5, 0, 0, 65536, 65536}},
      '{1, 3, 1, 7, 1, 3, -1, -1, 32'h13579BDF, 32'h00000010, 0, result_t'(0)}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].wr_w || plan[i].wr_h)
        set_frame_size(plan[i].wr_w, plan[i].w, plan[i].wr_h, plan[i].h);
      send_planned_frame(plan[i]);
    end

    phase = 0;
    while (random_sent < RANDOM_PIXELS) begin
      if (phase == 0) begin
        // Tiny frames with the receiver held off: the input has to stall.
        set_frame_size(1'b1, 13'd2, 1'b1, 13'd1);
        squeeze_go = 1'b1;
        repeat (40) send_random_frame($urandom_range(3));
      end else begin
        pick = $urandom_range(9);
        case (pick)
          0: begin w = 13'd0; h = 13'($urandom_range(1, 6)); end
          1: begin w = 13'($urandom_range(1, 6)); h = 13'd0; end
          2: begin w = 13'($urandom_range(20, 64)); h = 13'd1; end
          3: begin w = 13'd1; h = 13'($urandom_range(8, 24)); end
          default: begin w = 13'($urandom_range(1, 8)); h = 13'($urandom_range(1, 6)); end
        endcase
        set_frame_size(pick != 4, w, pick != 5, h);
        no_idle = (phase >= 3 && phase <= 6);
        repeat ((pick == 2) ? 2 : $urandom_range(2, 8)) send_random_frame($urandom_range(3));
      end
      phase++;
    end

    wait_idle();
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
